// ===== rtl/rfcd_pkg.sv =====
// ============================================================================
// rfcd_pkg - shared types and constants for the CRC16 radio frame deframer
// Holds status codes, register indexes, reset values and the CRC byte step.
// ============================================================================
package rfcd_pkg;

    // Default payload buffer depth and command queue depth
    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int CMDQ_DEPTH_DEF  = 4;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SYNC  = 3'd0;
    localparam logic [2:0] REG_POLY  = 3'd1;
    localparam logic [2:0] REG_START = 3'd2;
    localparam logic [2:0] REG_END   = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    // Register reset values
    localparam logic [7:0]  SYNC_RST  = 8'h00;
    localparam logic [15:0] POLY_RST  = 16'h8005;
    localparam logic [15:0] START_RST = 16'hFFFF;
    localparam logic [7:0]  END_RST   = 8'h16;
    localparam logic [5:0]  COUNT_RST = 6'd28;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_HDR  = 3'd1,
        ST_LEN  = 3'd2,
        ST_CRC  = 3'd3,
        ST_STOP = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_start;
        logic [7:0]  end_marker;
        logic [5:0]  payload_count;
    } cfg_t;

    // One queued job: an error report, or a good frame to replay from a bank
    typedef struct packed {
        status_t    status;
        logic [7:0] rssi;
        logic [7:0] cnt;
        logic       bank;
    } cmd_t;

    // Payload bank handed back by the emitter
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    // Result item waiting for its memory data
    typedef struct packed {
        logic       is_data;
        logic [7:0] rssi;
        status_t    status;
        logic       last;
    } meta_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] rssi;
        status_t    status;
        logic       last;
    } out_t;

    // MSB-first CRC16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  d,
                                               input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int b = 0; b < 8; b++) begin
            fb = c[15] ^ d[7-b];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/rfcd_cfg.sv =====
// ============================================================================
// rfcd_cfg - configuration register file
// APB-style write/read of the five deframer registers.
// ============================================================================
module rfcd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfcd_pkg::ADDR_W-1:0] paddr,
    input  logic [rfcd_pkg::DATA_W-1:0] pwdata,
    output logic [rfcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rfcd_pkg::cfg_t             cfg
);
    import rfcd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte      <= SYNC_RST;
            cfg_reg.crc_polynomial <= POLY_RST;
            cfg_reg.crc_start      <= START_RST;
            cfg_reg.end_marker     <= END_RST;
            cfg_reg.payload_count  <= COUNT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_SYNC:  cfg_reg.sync_byte      <= pwdata[7:0];
                REG_POLY:  cfg_reg.crc_polynomial <= pwdata[15:0];
                REG_START: cfg_reg.crc_start      <= pwdata[15:0];
                REG_END:   cfg_reg.end_marker     <= pwdata[7:0];
                REG_COUNT: cfg_reg.payload_count  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SYNC:  prdata = {24'd0, cfg_reg.sync_byte};
            REG_POLY:  prdata = {16'd0, cfg_reg.crc_polynomial};
            REG_START: prdata = {16'd0, cfg_reg.crc_start};
            REG_END:   prdata = {24'd0, cfg_reg.end_marker};
            REG_COUNT: prdata = {26'd0, cfg_reg.payload_count};
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rfcd_front.sv =====
// ============================================================================
// rfcd_front - frame parser
// Accepts one byte a cycle unless stalled; tracks the frame, checks CRC, queues jobs.
// ============================================================================
module rfcd_front #(
    parameter int MAX_PAYLOAD = rfcd_pkg::MAX_PAYLOAD_DEF,
    parameter int IW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  rfcd_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    output logic            push,
    output rfcd_pkg::cmd_t  push_cmd,
    input  logic            q_full,
    output logic            wr_en,
    output logic            wr_bank,
    output logic [AW-1:0]   wr_idx,
    output logic [7:0]      wr_data,
    input  rfcd_pkg::rel_t  rel
);
    import rfcd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT, PH_HEADER, PH_LENGTH, PH_PAYLOAD,
        PH_RSSI, PH_CRC_HI, PH_CRC_LO, PH_STOP
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [15:0]   crc_reg, crc_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]    rssi_reg, rssi_next;
    logic [15:0]   rxcrc_reg, rxcrc_next;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic [8:0]    pc9;
    logic [8:0]    eff9;
    logic [IW-1:0] idx_inc;
    logic [15:0]   crc_upd;

    assign s_tready = !q_full && !(phase_reg == PH_PAYLOAD && busy_reg[bank_reg]);
    assign accept   = s_tvalid && s_tready;
    assign pc9      = {3'd0, cfg.payload_count};
    assign eff9     = (pc9 == 9'd0) ? 9'd1 :
                      ((pc9 > 9'(MAX_PAYLOAD)) ? 9'(MAX_PAYLOAD) : pc9);
    assign idx_inc  = idx_reg + IW'(1);
    assign crc_upd  = crc16_byte(crc_reg, s_tdata, cfg.crc_polynomial);
    assign wr_bank  = bank_reg;
    assign wr_idx   = idx_reg[AW-1:0];
    assign wr_data  = s_tdata;

    always_comb begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        idx_next        = idx_reg;
        rssi_next       = rssi_reg;
        rxcrc_next      = rxcrc_reg;
        bank_next       = bank_reg;
        busy_next       = busy_reg;
        push            = 1'b0;
        push_cmd.status = ST_OK;
        push_cmd.rssi   = 8'd0;
        push_cmd.cnt    = 8'(idx_reg);
        push_cmd.bank   = bank_reg;
        wr_en           = 1'b0;

        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_tdata == cfg.sync_byte) begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_HEADER: begin
                    if (s_tdata == cfg.sync_byte) begin
                        phase_next = PH_LENGTH;
                    end else begin
                        push            = 1'b1;
                        push_cmd.status = ST_HDR;
                        phase_next      = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    if ({1'b0, s_tdata} == eff9 + 9'd1) begin
                        crc_next   = crc16_byte(cfg.crc_start, s_tdata,
                                                cfg.crc_polynomial);
                        idx_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end else begin
                        push            = 1'b1;
                        push_cmd.status = ST_LEN;
                        phase_next      = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next = crc_upd;
                    if (9'(idx_reg) < 9'(MAX_PAYLOAD)) begin
                        wr_en    = 1'b1;
                        idx_next = idx_inc;
                        if (9'(idx_inc) >= eff9) begin
                            phase_next = PH_RSSI;
                        end
                    end else if (9'(idx_reg) >= eff9) begin
                        phase_next = PH_RSSI;
                    end
                end
                PH_RSSI: begin
                    rssi_next  = s_tdata;
                    crc_next   = crc_upd;
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    rxcrc_next = {s_tdata, rxcrc_reg[7:0]};
                    phase_next = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    rxcrc_next = {rxcrc_reg[15:8], s_tdata};
                    phase_next = PH_STOP;
                end
                PH_STOP: begin
                    push          = 1'b1;
                    push_cmd.rssi = rssi_reg;
                    if (rxcrc_reg != crc_reg) begin
                        push_cmd.status = ST_CRC;
                    end else if (s_tdata != cfg.end_marker) begin
                        push_cmd.status = ST_STOP;
                    end else begin
                        // good frame: lock this bank until replayed, flip to the other
                        push_cmd.status     = ST_OK;
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = !bank_reg;
                    end
                    phase_next = PH_HEADER;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            crc_reg   <= '0;
            idx_reg   <= '0;
            rssi_reg  <= '0;
            rxcrc_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            idx_reg   <= idx_next;
            rssi_reg  <= rssi_next;
            rxcrc_reg <= rxcrc_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !busy_reg[wr_bank])
        else $error("payload write into a bank still being replayed");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_cmd.status == ST_OK) |=> bank_reg != $past(bank_reg))
        else $error("good frame did not switch payload bank");

endmodule

// ===== rtl/rfcd_cmdq.sv =====
// ============================================================================
// rfcd_cmdq - job queue
// Small FIFO of parsed jobs between the parser and the emitter.
// ============================================================================
module rfcd_cmdq #(
    parameter int DEPTH = rfcd_pkg::CMDQ_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rfcd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rfcd_pkg::cmd_t head
);
    import rfcd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          q_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = q_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rfcd_back.sv =====
// ============================================================================
// rfcd_back - result emitter
// Double-banked payload buffer; replays good frames and sends status items.
// ============================================================================
module rfcd_back #(
    parameter int MAX_PAYLOAD = rfcd_pkg::MAX_PAYLOAD_DEF,
    parameter int IW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_empty,
    input  rfcd_pkg::cmd_t cmd_head,
    output logic           cmd_pop,
    input  logic           wr_en,
    input  logic           wr_bank,
    input  logic [AW-1:0]  wr_idx,
    input  logic [7:0]     wr_data,
    output rfcd_pkg::rel_t rel,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);
    import rfcd_pkg::*;

    logic [7:0]    mem [2][MAX_PAYLOAD];
    logic [7:0]    rd_q_reg;

    logic          job_act_reg, job_act_next;
    cmd_t          job_reg, job_next;
    logic [IW-1:0] pos_reg, pos_next;

    logic          infl_reg;
    meta_t         infl_meta_reg;

    out_t          ob_reg [2];
    logic          ob_wp_reg, ob_rp_reg;
    logic [1:0]    ob_cnt_reg, ob_cnt_next;

    logic          pop_out;
    logic [2:0]    occ;
    logic          issue;
    meta_t         meta;
    logic          rd_bank;
    logic [IW-1:0] rd_pos;
    out_t          ob_in;
    out_t          ob_head;

    assign ob_head  = ob_reg[ob_rp_reg];
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = {ob_head.rssi, ob_head.data};
    assign m_tuser  = ob_head.status;
    assign m_tlast  = ob_head.last;
    assign pop_out  = m_tvalid && m_tready;
    // buffer occupancy after this cycle's transfer, counting the read in flight
    assign occ      = {1'b0, ob_cnt_reg} + {2'd0, infl_reg} - {2'd0, pop_out};

    always_comb begin
        issue        = 1'b0;
        cmd_pop      = 1'b0;
        rel.valid    = 1'b0;
        rel.bank     = job_reg.bank;
        job_act_next = job_act_reg;
        job_next     = job_reg;
        pos_next     = pos_reg;
        rd_bank      = job_reg.bank;
        rd_pos       = pos_reg;
        meta.is_data = 1'b1;
        meta.rssi    = job_reg.rssi;
        meta.status  = ST_OK;
        meta.last    = 1'b0;

        if (occ < 3'd2) begin
            if (job_act_reg) begin
                issue     = 1'b1;
                meta.last = (8'(pos_reg) + 8'd1 == job_reg.cnt);
                pos_next  = pos_reg + IW'(1);
                if (meta.last) begin
                    job_act_next = 1'b0;
                    rel.valid    = 1'b1;
                end
            end else if (!cmd_empty) begin
                issue     = 1'b1;
                cmd_pop   = 1'b1;
                meta.rssi = cmd_head.rssi;
                if (cmd_head.status != ST_OK) begin
                    meta.is_data = 1'b0;
                    meta.status  = cmd_head.status;
                    meta.last    = 1'b1;
                end else begin
                    rd_bank   = cmd_head.bank;
                    rd_pos    = '0;
                    meta.last = (cmd_head.cnt == 8'd1);
                    if (meta.last) begin
                        rel.valid = 1'b1;
                        rel.bank  = cmd_head.bank;
                    end else begin
                        job_act_next = 1'b1;
                        job_next     = cmd_head;
                        pos_next     = IW'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        ob_in.data   = infl_meta_reg.is_data ? rd_q_reg : 8'd0;
        ob_in.rssi   = infl_meta_reg.rssi;
        ob_in.status = infl_meta_reg.status;
        ob_in.last   = infl_meta_reg.last;
        ob_cnt_next  = ob_cnt_reg;
        if (infl_reg && !pop_out) begin
            ob_cnt_next = ob_cnt_reg + 2'd1;
        end else if (pop_out && !infl_reg) begin
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_act_reg <= 1'b0;
            infl_reg    <= 1'b0;
            ob_wp_reg   <= 1'b0;
            ob_rp_reg   <= 1'b0;
            ob_cnt_reg  <= '0;
            pos_reg     <= '0;
        end else begin
            job_act_reg <= job_act_next;
            infl_reg    <= issue;
            ob_cnt_reg  <= ob_cnt_next;
            pos_reg     <= pos_next;
            if (infl_reg) begin
                ob_wp_reg <= !ob_wp_reg;
            end
            if (pop_out) begin
                ob_rp_reg <= !ob_rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (issue) begin
            infl_meta_reg <= meta;
        end
        if (infl_reg) begin
            ob_reg[ob_wp_reg] <= ob_in;
        end
    end

    // payload buffer: one write port from the parser, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_bank][wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_q_reg <= mem[rd_bank][rd_pos[AW-1:0]];
        end
    end

    a_ob_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, ob_cnt_reg} + {2'd0, infl_reg}) <= 3'd2)
        else $error("output buffer overrun");

    a_job_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        job_act_reg |-> (job_reg.status == ST_OK && 8'(pos_reg) < job_reg.cnt))
        else $error("replay job past its frame length");

    a_rel_last: assert property (@(posedge aclk) disable iff (!aresetn)
        rel.valid |-> (issue && meta.is_data && meta.last))
        else $error("bank released before its last byte was read");

endmodule

// ===== rtl/radio_frame_crc16_deframer.sv =====
// ============================================================================
// radio_frame_crc16_deframer - serial frame deframer with CRC16 check
// Path: a result item passes the job queue, the registered read stage and the output buffer on its way to m_*.
// Throughput: one byte per cycle in, one result item per cycle out while m_tready is high.
// Input stalls only when the job queue is full, or when a payload byte would
// land in a buffer bank whose frame has not finished replaying.
// Reset: aresetn synchronous, active low; parser hunts for a header, queue and
// output empty, registers at defaults; payload buffer is not cleared.
// ============================================================================
module radio_frame_crc16_deframer #(
    parameter int MAX_PAYLOAD = rfcd_pkg::MAX_PAYLOAD_DEF,
    parameter int CMD_DEPTH   = rfcd_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfcd_pkg::ADDR_W-1:0] paddr,
    input  logic [rfcd_pkg::DATA_W-1:0] pwdata,
    output logic [rfcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // received byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // [7:0] data_byte, [15:8] signal_strength
    output logic [2:0]                  m_tuser,  // [2:0] status
    output logic                        m_tlast
);
    import rfcd_pkg::*;

    localparam int IW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    cfg_t          cfg;
    logic          push;
    cmd_t          push_cmd;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    cmd_t          q_head;
    logic          wr_en;
    logic          wr_bank;
    logic [AW-1:0] wr_idx;
    logic [7:0]    wr_data;
    rel_t          rel;

    // register file
    rfcd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser: one byte per transfer, checks header, length, CRC and stop byte,
    // writes payload into the current bank and queues one job per outcome
    rfcd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IW          (IW),
        .AW          (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rel      (rel)
    );

    // decouple parsing from emission so a long payload replay does not hold
    // back the next frame's header bytes
    rfcd_cmdq #(
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // emitter: replay good frames byte by byte, send error status items,
    // hand each bank back after its last byte is read
    rfcd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IW          (IW),
        .AW          (AW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (q_empty),
        .cmd_head  (q_head),
        .cmd_pop   (q_pop),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .rel       (rel),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/sv/rfcd_frame_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rfcd_frame_checker - scoreboard for the CRC16 radio frame deframer
// Follows register writes and accepted bytes, predicts the result transfers
// of the deframer and compares every accepted result field by field.
// ============================================================================
package rfcd_tb_pkg;

    // MSB-first CRC16 over one byte, top polynomial bit implicit
    function automatic logic [15:0] crc16_next(input logic [15:0] acc,
                                               input logic [7:0]  din,
                                               input logic [15:0] poly);
        logic [15:0] r;
        logic [7:0]  d;
        logic        fb;
        r = acc;
        d = din;
        repeat (8) begin
            fb = r[15] ^ d[7];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ poly;
            end
            d = {d[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

module rfcd_frame_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rfcd_pkg::ADDR_W-1:0] paddr,
    input  logic [rfcd_pkg::DATA_W-1:0] pwdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,  // [7:0] data_byte, [15:8] signal_strength
    input  logic [2:0]                  m_tuser,  // [2:0] status
    input  logic                        m_tlast,
    output int                          error_total,
    output int                          results_due,
    output int                          bytes_seen,
    output int                          results_seen,
    output int                          good_frames,
    output int                          status_reports
);
    import rfcd_pkg::*;
    import rfcd_tb_pkg::*;

    localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
    localparam int OWED_SLOTS  = 256;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_RSSI,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_STOP
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic [7:0] rssi;
        status_t    status;
        logic       last;
    } frame_item_t;

    logic [7:0]   cfg_sync;
    logic [15:0]  cfg_poly;
    logic [15:0]  cfg_start;
    logic [7:0]   cfg_stop;
    logic [5:0]   cfg_count;

    parse_phase_t phase;
    logic [15:0]  crc_acc;
    int           fill;
    logic [7:0]   payload_buf [PAYLOAD_MAX];
    logic [7:0]   rssi_hold;
    logic [15:0]  crc_rx;
    frame_item_t  owed_results [OWED_SLOTS];
    int           owed_rd;
    int           owed_count;

    function automatic int payload_len();
        if (cfg_count == 0) begin
            return 1;
        end
        return (cfg_count > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(cfg_count);
    endfunction

    task automatic owe_result(input logic [7:0] data, input logic [7:0] rssi,
                              input status_t status, input logic last);
        frame_item_t item;
        item.data   = data;
        item.rssi   = rssi;
        item.status = status;
        item.last   = last;
        if (owed_count == OWED_SLOTS) begin
            $error("too many results outstanding");
            error_total++;
        end else begin
            owed_results[(owed_rd + owed_count) % OWED_SLOTS] = item;
            owed_count++;
        end
        if (status != ST_OK) begin
            status_reports++;
        end
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        case (idx)
            REG_SYNC:  cfg_sync  = value[7:0];
            REG_POLY:  cfg_poly  = value[15:0];
            REG_START: cfg_start = value[15:0];
            REG_END:   cfg_stop  = value[7:0];
            REG_COUNT: cfg_count = value[5:0];
            default: ;  // drop writes beyond the register list
        endcase
    endtask

    task automatic deframe_byte(input logic [7:0] rx);
        int cnt;
        bytes_seen++;
        case (phase)
            PH_HUNT: begin
                if (rx == cfg_sync) begin
                    phase = PH_LENGTH;
                end
            end
            PH_HEADER: begin
                if (rx == cfg_sync) begin
                    phase = PH_LENGTH;
                end else begin
                    owe_result(8'h00, 8'h00, ST_HDR, 1'b1);
                    phase = PH_HUNT;
                end
            end
            PH_LENGTH: begin
                if (int'(rx) == payload_len() + 1) begin
                    crc_acc = crc16_next(cfg_start, rx, cfg_poly);
                    fill    = 0;
                    phase   = PH_PAYLOAD;
                end else begin
                    owe_result(8'h00, 8'h00, ST_LEN, 1'b1);
                    phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (fill < PAYLOAD_MAX) begin
                    payload_buf[fill] = rx;
                    fill++;
                end
                crc_acc = crc16_next(crc_acc, rx, cfg_poly);
                if (fill >= payload_len()) begin
                    phase = PH_RSSI;
                end
            end
            PH_RSSI: begin
                rssi_hold = rx;
                crc_acc   = crc16_next(crc_acc, rx, cfg_poly);
                phase     = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                crc_rx = {rx, 8'h00};
                phase  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_rx[7:0] = rx;
                phase       = PH_STOP;
            end
            default: begin
                if (crc_rx != crc_acc) begin
                    owe_result(8'h00, rssi_hold, ST_CRC, 1'b1);
                end else if (rx != cfg_stop) begin
                    owe_result(8'h00, rssi_hold, ST_STOP, 1'b1);
                end else begin
                    cnt = (fill > PAYLOAD_MAX) ? PAYLOAD_MAX : fill;
                    for (int i = 0; i < cnt; i++) begin
                        owe_result(payload_buf[i], rssi_hold, ST_OK, (i + 1 == cnt));
                    end
                    good_frames++;
                end
                phase = PH_HEADER;
            end
        endcase
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_total++;
        end
    endfunction

    task automatic check_result(input logic [15:0] td, input logic [2:0] tu,
                                input logic tl);
        frame_item_t want;
        results_seen++;
        if (owed_count == 0) begin
            $error("result transfer with nothing expected: tdata 0x%0h, tuser %0d, tlast %0b",
                   td, tu, tl);
            error_total++;
        end else begin
            want       = owed_results[owed_rd];
            owed_rd    = (owed_rd + 1) % OWED_SLOTS;
            owed_count--;
            compare_field("data_byte", want.data, td[7:0]);
            compare_field("signal_strength", want.rssi, td[15:8]);
            compare_field("status", {5'b0, want.status}, {5'b0, tu});
            compare_field("last", {7'b0, want.last}, {7'b0, tl});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_sync       = SYNC_RST;
            cfg_poly       = POLY_RST;
            cfg_start      = START_RST;
            cfg_stop       = END_RST;
            cfg_count      = COUNT_RST;
            phase          = PH_HUNT;
            crc_acc        = '0;
            fill           = 0;
            rssi_hold      = '0;
            crc_rx         = '0;
            owed_rd        = 0;
            owed_count     = 0;
            error_total    = 0;
            bytes_seen     = 0;
            results_seen   = 0;
            good_frames    = 0;
            status_reports = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                write_register(paddr[ADDR_W-1:2], pwdata);
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser, m_tlast);
            end
        end
        results_due = owed_count;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top - stimulus and verdict for the CRC16 radio frame deframer
// Feeds directed and random byte streams (good frames, damaged frames and
// line noise) under several register settings, with bursty input and a
// stalling result side; the frame checker predicts and compares results.
// ============================================================================
module tb_top;
    import rfcd_pkg::*;
    import rfcd_tb_pkg::*;

    localparam int         PAYLOAD_MAX   = MAX_PAYLOAD_DEF;
    localparam logic [2:0] REG_SPARE     = 3'd5;     // first index past the register list
    localparam int         RANDOM_PHASES = 5;
    localparam int         PHASE_BYTES   = 80;       // byte budget of one random phase
    localparam int         SETTLE_CYCLES = 10;       // settle time after the last expected result
    localparam int         RUN_LIMIT_NS  = 400_000;  // far beyond the slowest correct run

    // Ways to damage an otherwise good frame
    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_STOP,
        FLAW_BOTH,
        FLAW_LEN,
        FLAW_BYTE
    } frame_flaw_t;

    // Result-side ready patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_ONE_IN_FOUR,
        RDY_MOSTLY
    } ready_pattern_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;  // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;           // [7:0] data_byte, [15:8] signal_strength
    logic [2:0]          m_tuser;           // [2:0] status
    logic                m_tlast;

    int error_total;
    int results_due;
    int bytes_seen;
    int results_seen;
    int good_frames;
    int status_reports;

    // Register values as last written; used only to build frames
    logic [7:0]     tx_sync  = SYNC_RST;
    logic [15:0]    tx_poly  = POLY_RST;
    logic [15:0]    tx_start = START_RST;
    logic [7:0]     tx_stop  = END_RST;
    logic [5:0]     tx_count = COUNT_RST;

    int             burst_left = 0;
    int             bytes_sent = 0;
    ready_pattern_t ready_mode = RDY_ALWAYS;
    int             ready_left = 0;

    always #1 aclk = ~aclk;

    radio_frame_crc16_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rfcd_frame_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .error_total    (error_total),
        .results_due    (results_due),
        .bytes_seen     (bytes_seen),
        .results_seen   (results_seen),
        .good_frames    (good_frames),
        .status_reports (status_reports)
    );

    // Result side: switch between ready patterns at random intervals so that
    // stalls land on every part of a replayed frame, with stretches of
    // constant ready in between.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_pattern_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 96);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            RDY_ALWAYS:      m_tready <= 1'b1;
            RDY_COIN:        m_tready <= ($urandom_range(0, 1) == 1);
            RDY_ONE_IN_FOUR: m_tready <= (ready_left % 4 == 0);
            default:         m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Write one register: setup cycle, access cycle, then an idle cycle so
    // that back-to-back writes never drive psel twice in the same step.
    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Write every register and keep a copy for frame building
    task automatic set_config(input logic [7:0] sync_val, input logic [15:0] poly_val,
                              input logic [15:0] start_val, input logic [7:0] stop_val,
                              input logic [5:0] count_val);
        apb_write(REG_SYNC, DATA_W'(sync_val));
        apb_write(REG_POLY, DATA_W'(poly_val));
        apb_write(REG_START, DATA_W'(start_val));
        apb_write(REG_END, DATA_W'(stop_val));
        apb_write(REG_COUNT, DATA_W'(count_val));
        tx_sync  = sync_val;
        tx_poly  = poly_val;
        tx_start = start_val;
        tx_stop  = stop_val;
        tx_count = count_val;
    endtask

    // Offer one byte and hold it until the transfer happens. The sender works
    // in bursts; when a burst runs out, drop valid for a random gap first.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result has been seen, then
    // let the pipeline settle so a register write finds the block idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Build a frame for the current settings with random payload and signal
    // strength, optionally damage it, and send it.
    // Byte layout: 0 header, 1 length, 2..n+1 payload, n+2 signal strength,
    // n+3 and n+4 check value, n+5 stop byte.
    task automatic send_frame(input frame_flaw_t flaw);
        logic [7:0]  fr [PAYLOAD_MAX + 6];
        logic [15:0] crc;
        int          n;
        int          pos;
        if (tx_count == 0) begin
            n = 1;
        end else begin
            n = (tx_count > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(tx_count);
        end
        fr[0] = tx_sync;
        fr[1] = 8'(n + 1);
        for (int i = 2; i < n + 3; i++) begin
            fr[i] = 8'($urandom);
        end
        crc = tx_start;
        for (int i = 1; i < n + 3; i++) begin
            crc = crc16_next(crc, fr[i], tx_poly);
        end
        fr[n + 3] = crc[15:8];
        fr[n + 4] = crc[7:0];
        fr[n + 5] = tx_stop;
        pos = n + 3 + $urandom_range(0, 1);
        case (flaw)
            FLAW_CRC:  fr[pos] ^= 8'($urandom_range(1, 255));
            FLAW_STOP: fr[n + 5] ^= 8'($urandom_range(1, 255));
            FLAW_BOTH: begin
                fr[pos] ^= 8'($urandom_range(1, 255));
                fr[n + 5] ^= 8'($urandom_range(1, 255));
            end
            FLAW_LEN:  fr[1] ^= 8'($urandom_range(1, 255));
            FLAW_BYTE: fr[$urandom_range(0, n + 5)] = 8'($urandom);
            default: ;
        endcase
        for (int i = 0; i < n + 6; i++) begin
            send_byte(fr[i]);
        end
    endtask

    initial begin : stimulus
        logic [15:0] cut_crc;
        logic [7:0]  cut_bytes [5];  // length, three payload bytes, signal strength
        int          pick;
        int          phase_start;

        // Hold reset at the start, once
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: one-byte payload, all-ones header and polynomial,
        // zero start value and stop byte. The write past the register list
        // must leave every setting alone.
        set_config(8'hFF, 16'hFFFF, 16'h0000, 8'h00, 6'd1);
        apb_write(REG_SPARE, '1);
        send_byte(8'h00);          // noise while hunting: dropped
        send_frame(FLAW_NONE);     // good frame
        send_byte(8'h5A);          // header expected, something else came
        send_byte(8'hFF);
        send_byte(8'h07);          // wrong length byte
        send_frame(FLAW_BOTH);     // bad check value and stop byte: CRC error wins
        send_frame(FLAW_STOP);     // good check value, bad stop byte

        // Shrink the payload count in the middle of a frame: the payload ends
        // at the next byte and the good frame replays all three bytes.
        wait_idle();
        apb_write(REG_COUNT, DATA_W'(4));
        tx_count = 6'd4;
        cut_bytes[0] = 8'd5;
        for (int i = 1; i < 5; i++) begin
            cut_bytes[i] = 8'($urandom);
        end
        cut_crc = tx_start;
        for (int i = 0; i < 5; i++) begin
            cut_crc = crc16_next(cut_crc, cut_bytes[i], tx_poly);
        end
        send_byte(tx_sync);
        send_byte(cut_bytes[0]);
        send_byte(cut_bytes[1]);
        send_byte(cut_bytes[2]);
        wait_idle();
        apb_write(REG_COUNT, DATA_W'(1));
        tx_count = 6'd1;
        send_byte(cut_bytes[3]);
        send_byte(cut_bytes[4]);
        send_byte(cut_crc[15:8]);
        send_byte(cut_crc[7:0]);
        send_byte(tx_stop);

        // Random part: one register setting per phase, mostly good frames
        // with random content, the rest damaged frames and line noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: set_config(8'h00, 16'h0000, 16'hFFFF, 8'hFF, 6'd0);
                1: set_config(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                              6'($urandom_range(1, 8)));
                2: set_config(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                              6'($urandom_range(33, 63)));
                3: set_config(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                              6'($urandom_range(2, 12)));
                default: set_config(8'($urandom), 16'hFFFF, 16'h0000, 8'($urandom),
                                    6'($urandom_range(1, 6)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    send_frame(FLAW_NONE);
                end else if (pick < 70) begin
                    send_frame(FLAW_CRC);
                end else if (pick < 76) begin
                    send_frame(FLAW_STOP);
                end else if (pick < 80) begin
                    send_frame(FLAW_BOTH);
                end else if (pick < 85) begin
                    send_frame(FLAW_LEN);
                end else if (pick < 92) begin
                    send_frame(FLAW_BYTE);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
        end

        // Drain every expected result, then give the pipeline time to show
        // anything extra.
        wait_idle();
        $display("covered %0d received bytes and %0d result transfers checked",
                 bytes_seen, results_seen);
        $display("%0d good frames replayed, %0d error reports, a mid-frame count change",
                 good_frames, status_reports);
        if (error_total == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
